// ===== rtl/dsdp_pkg.sv =====
`timescale 1ns / 1ps

package dsdp_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int CHAN_IDX_W   = $clog2(MAX_CHANNELS) > 0 ? $clog2(MAX_CHANNELS) : 1;
  localparam int CHAN_CNT_W   = 4;
  localparam int BYTE_W       = 8;
  localparam int WORD_W       = 24;
  localparam int FRAME_W      = 41;
  localparam int SCOUNT_W     = 44;
  localparam int SCALED_W     = FRAME_W + 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = SCOUNT_W;

  localparam logic [BYTE_W-1:0] MARKER_EVEN = 8'hFA;
  localparam logic [BYTE_W-1:0] MARKER_ODD  = 8'h05;

  localparam logic [CHAN_CNT_W-1:0] CHAN_CNT_RESET = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT     = 3'd0,
    REG_MSB_FIRST_SOURCE  = 3'd1,
    REG_MARKER_PER_SAMPLE = 3'd2,
    REG_NATIVE_MODE       = 3'd3,
    REG_SAMPLE_COUNT      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAN_IDX_W-1:0] chan_last;     // clamped channel count minus one
    logic                  msb_first;
    logic                  marker_per_sample;
    logic                  native_mode;
    logic [SCOUNT_W-1:0]   sample_count;
  } cfg_t;

  // bit reversal of one byte by pair, nibble and half swaps
  function automatic logic [BYTE_W-1:0] flip8(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] t;
    t = ((b >> 1) & 8'h55) | ((b & 8'h55) << 1);
    t = ((t >> 2) & 8'h33) | ((t & 8'h33) << 2);
    t = ((t >> 4) & 8'h0F) | ((t & 8'h0F) << 4);
    return t;
  endfunction

endpackage

// ===== rtl/dsdp_if.sv =====
`timescale 1ns / 1ps

interface dsdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_byte;
  logic [7:0] second_byte;

  modport source (output valid, output first_byte, output second_byte, input ready);
  modport sink   (input valid, input first_byte, input second_byte, output ready);
endinterface

interface dsdp_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] out_word;
  logic        frame_last;
  logic        stream_end;

  modport source (output valid, output out_word, output frame_last, output stream_end,
                  input ready);
  modport sink   (input valid, input out_word, input frame_last, input stream_end,
                  output ready);
endinterface

// ===== rtl/dsdp_cfg_regs.sv =====
`timescale 1ns / 1ps

module dsdp_cfg_regs
  import dsdp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  logic [CHAN_CNT_W-1:0] chan_cnt_r;
  logic                  msb_first_r;
  logic                  marker_ps_r;
  logic                  native_r;
  logic [SCOUNT_W-1:0]   scount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r  <= CHAN_CNT_RESET;
      msb_first_r <= 1'b0;
      marker_ps_r <= 1'b0;
      native_r    <= 1'b0;
      scount_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CHANNEL_COUNT:     chan_cnt_r  <= cfg_wdata[CHAN_CNT_W-1:0];
        REG_MSB_FIRST_SOURCE:  msb_first_r <= cfg_wdata[0];
        REG_MARKER_PER_SAMPLE: marker_ps_r <= cfg_wdata[0];
        REG_NATIVE_MODE:       native_r    <= cfg_wdata[0];
        REG_SAMPLE_COUNT:      scount_r    <= cfg_wdata[SCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero behaves as one channel, anything above the maximum as the maximum
  always_comb begin
    if (chan_cnt_r == '0) begin
      cfg.chan_last = '0;
    end else if (chan_cnt_r > CHAN_CNT_W'(MAX_CHANNELS)) begin
      cfg.chan_last = CHAN_IDX_W'(MAX_CHANNELS - 1);
    end else begin
      cfg.chan_last = CHAN_IDX_W'(chan_cnt_r - 1'b1);
    end
    cfg.msb_first         = msb_first_r;
    cfg.marker_per_sample = marker_ps_r;
    cfg.native_mode       = native_r;
    cfg.sample_count      = scount_r;
  end

endmodule

// ===== rtl/dsdp_in_stage.sv =====
`timescale 1ns / 1ps

module dsdp_in_stage
  import dsdp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  dsdp_in_if.sink   up,
  dsdp_in_if.source dn
);

  logic              valid_r;
  logic [BYTE_W-1:0] first_r;
  logic [BYTE_W-1:0] second_r;

  assign up.ready = !valid_r || dn.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up.valid && up.ready) begin
      valid_r <= 1'b1;
    end else if (dn.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (up.valid && up.ready) begin
      first_r  <= up.first_byte;
      second_r <= up.second_byte;
    end
  end

  assign dn.valid       = valid_r;
  assign dn.first_byte  = first_r;
  assign dn.second_byte = second_r;

endmodule

// ===== rtl/dsdp_pack_core.sv =====
`timescale 1ns / 1ps

module dsdp_pack_core
  import dsdp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  dsdp_in_if.sink    in_s,
  dsdp_out_if.source out_s
);

  logic [FRAME_W-1:0]    frame_count_r;
  logic [CHAN_IDX_W-1:0] chan_idx_r;
  logic                  parity_r;
  logic                  done_r;

  logic                  out_valid_r;
  logic [WORD_W-1:0]     out_word_r;
  logic                  out_last_r;
  logic                  out_end_r;

  logic                  fire;
  logic                  emit;
  logic                  last;
  logic                  end_now;
  logic [BYTE_W-1:0]     b0;
  logic [BYTE_W-1:0]     b1;
  logic [BYTE_W-1:0]     marker;
  logic [WORD_W-1:0]     word;
  logic [FRAME_W-1:0]    fc_inc;
  logic [SCALED_W-1:0]   scaled;

  // once the stream has ended, items are drained without a result
  assign in_s.ready = done_r || !out_valid_r || out_s.ready;
  assign fire       = in_s.valid && in_s.ready;
  assign emit       = fire && !done_r;

  always_comb begin
    b0 = cfg.msb_first ? in_s.first_byte  : flip8(in_s.first_byte);
    b1 = cfg.msb_first ? in_s.second_byte : flip8(in_s.second_byte);
    if (cfg.marker_per_sample) begin
      marker = parity_r ? MARKER_ODD : MARKER_EVEN;
    end else begin
      marker = frame_count_r[0] ? MARKER_ODD : MARKER_EVEN;
    end
    if (cfg.native_mode) begin
      word   = {{(WORD_W-BYTE_W){1'b0}},
                (cfg.msb_first ? flip8(in_s.first_byte) : in_s.first_byte)};
      scaled = {1'b0, fc_inc, 3'b000};
    end else begin
      word   = {marker, b0, b1};
      scaled = {fc_inc, 4'b0000};
    end
  end

  // an index left past the count by a register change also closes the frame
  assign last    = chan_idx_r >= cfg.chan_last;
  assign fc_inc  = frame_count_r + 1'b1;
  assign end_now = last && (scaled >= {1'b0, cfg.sample_count});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
      chan_idx_r    <= '0;
      parity_r      <= 1'b0;
      done_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (emit) begin
        parity_r <= !parity_r;
        if (last) begin
          chan_idx_r    <= '0;
          frame_count_r <= fc_inc;
          done_r        <= end_now;
        end else begin
          chan_idx_r <= chan_idx_r + 1'b1;
        end
        out_valid_r <= 1'b1;
      end else if (out_s.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r <= word;
      out_last_r <= last;
      out_end_r  <= end_now;
    end
  end

  assign out_s.valid      = out_valid_r;
  assign out_s.out_word   = out_word_r;
  assign out_s.frame_last = out_last_r;
  assign out_s.stream_end = out_end_r;

  a_end_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
    emit && end_now |=> done_r)
    else $error("stream end transfer did not latch done");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("done cleared without reset");

  a_chan_step: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && emit && !last |=> chan_idx_r == $past(chan_idx_r) + 1'b1)
    else $error("channel index did not advance");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_end_r |-> out_last_r)
    else $error("stream end on a word that does not close a frame");

endmodule

// ===== rtl/dsd_to_dop_packer.sv =====
`timescale 1ns / 1ps

// DSD to DoP packer. Takes one channel's pair of DSD bytes per transfer on
// in_ch, channels interleaved frame by frame, and returns one word per
// transfer on out_ch: a DoP word (marker, first byte, second byte) or, in
// native mode, the first byte alone in bits 7..0. Throughput is one item per
// clock unless out_ch.ready stalls it; an item passes an input register and
// the result register before it appears on out_ch. in_ch.ready follows
// out_ch.ready combinationally through both registers. After the word
// flagged stream_end, further input is taken and discarded until reset.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.

module dsd_to_dop_packer
  import dsdp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  dsdp_in_if.sink               in_ch,
  dsdp_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  dsdp_in_if stage_ch ();

  dsdp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dsdp_in_stage u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .up    (in_ch),
    .dn    (stage_ch)
  );

  dsdp_pack_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .in_s  (stage_ch),
    .out_s (out_ch)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import dsdp_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              frame_last;
    logic              stream_end;
  } dop_word_t;

  typedef enum {STEP_CFG, STEP_PAIR} step_kind_t;

  typedef struct {
    step_kind_t            kind;
    cfg_reg_t              sel;
    logic [CFG_DATA_W-1:0] value;
    logic [BYTE_W-1:0]     fb;
    logic [BYTE_W-1:0]     sb;
    bit                    typed;
    dop_word_t             want;
  } step_t;

  localparam logic [SCOUNT_W-1:0] SCOUNT_MAX = '1;
  localparam int RANDOM_PAIRS = 400;
  localparam int CHOKE_CYCLES = 200;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dsdp_in_if  in_if ();
  dsdp_out_if out_if ();

  dsd_to_dop_packer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // packer state and settings as the block should hold them
  logic [CHAN_CNT_W-1:0] m_chans;
  logic                  m_msb;
  logic                  m_per_word;
  logic                  m_native;
  logic [SCOUNT_W-1:0]   m_samples;
  logic [FRAME_W-1:0]    frame_cnt;
  logic [2:0]            chan_idx;
  logic                  parity;
  logic                  ended;

  dop_word_t pending_words[$];
  step_t     script[$];
  int        errors = 0;
  bit        choke_req = 1'b0;

  function automatic logic [7:0] rev_byte(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = b[7 - i];
    return r;
  endfunction

  // returns 0 once the stream has ended: the pair is then dropped
  function automatic bit pack_channel_word(input logic [7:0] fb, input logic [7:0] sb,
                                           output dop_word_t res);
    logic [CHAN_CNT_W-1:0] chans;
    logic [7:0]            b0;
    logic [7:0]            b1;
    logic [7:0]            marker;
    logic [63:0]           scaled;
    bit                    last;
    res = '0;
    if (ended) return 1'b0;
    chans = m_chans;
    if (chans == 0) chans = 1;
    if (chans > MAX_CHANNELS) chans = CHAN_CNT_W'(MAX_CHANNELS);
    b0 = fb;
    b1 = sb;
    if (m_native) begin
      res.word = {16'h0000, m_msb ? rev_byte(b0) : b0};
    end else begin
      if (!m_msb) begin
        b0 = rev_byte(b0);
        b1 = rev_byte(b1);
      end
      if (m_per_word) marker = parity ? MARKER_ODD : MARKER_EVEN;
      else marker = frame_cnt[0] ? MARKER_ODD : MARKER_EVEN;
      res.word = {marker, b0, b1};
    end
    // an index left past a reduced count closes the frame
    last = ({1'b0, chan_idx} + 4'd1) >= chans;
    parity = ~parity;
    if (last) begin
      chan_idx = '0;
      frame_cnt = frame_cnt + 1'b1;
      scaled = {23'd0, frame_cnt} << (m_native ? 3 : 4);
      if (scaled >= {20'd0, m_samples}) begin
        res.stream_end = 1'b1;
        ended = 1'b1;
      end
    end else begin
      chan_idx = chan_idx + 1'b1;
    end
    res.frame_last = last;
    return 1'b1;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // large enough that the stream cannot end within a phase
  function automatic logic [SCOUNT_W-1:0] safe_samples();
    logic [63:0] floor_v;
    logic [63:0] v;
    if ($urandom_range(0, 3) == 0) return SCOUNT_MAX;
    floor_v = ({23'd0, frame_cnt} + 64'd4096) * 64'd16;
    v = {$urandom, $urandom} & {20'd0, SCOUNT_MAX};
    if (v < floor_v) v = floor_v + 64'($urandom_range(0, 4095));
    return v[SCOUNT_W-1:0];
  endfunction

  function automatic void add_cfg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] v);
    step_t s;
    s.kind  = STEP_CFG;
    s.sel   = sel;
    s.value = v;
    s.fb    = '0;
    s.sb    = '0;
    s.typed = 1'b0;
    s.want  = '0;
    script.push_back(s);
  endfunction

  function automatic void add_pair(input logic [7:0] fb, input logic [7:0] sb,
                                   input bit typed, input logic [23:0] word, input bit last);
    step_t s;
    s.kind  = STEP_PAIR;
    s.sel   = REG_CHANNEL_COUNT;
    s.value = '0;
    s.fb    = fb;
    s.sb    = sb;
    s.typed = typed;
    s.want  = '{word: word, frame_last: last, stream_end: 1'b0};
    script.push_back(s);
  endfunction

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("%0t ns  %s: got %06h, expected %06h", $time, what, got, want);
    errors++;
  endtask

  task automatic cfg_write(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (sel)
      REG_CHANNEL_COUNT:     m_chans    = v[CHAN_CNT_W-1:0];
      REG_MSB_FIRST_SOURCE:  m_msb      = v[0];
      REG_MARKER_PER_SAMPLE: m_per_word = v[0];
      REG_NATIVE_MODE:       m_native   = v[0];
      REG_SAMPLE_COUNT:      m_samples  = v[SCOUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_pair(input logic [7:0] fb, input logic [7:0] sb, input bit typed,
                           input dop_word_t want, input bit calm);
    int        gap;
    dop_word_t res;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.first_byte  <= fb;
    in_if.second_byte <= sb;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (pack_channel_word(fb, sb, res)) pending_words.push_back(typed ? want : res);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // result side: random back-pressure and checking
  initial begin : rx_side
    int        stall_left;
    int        calm_left;
    int        r;
    dop_word_t got;
    dop_word_t want;
    stall_left = 0;
    calm_left  = 0;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        got = '{word: out_if.out_word, frame_last: out_if.frame_last,
                stream_end: out_if.stream_end};
        if (pending_words.size() == 0) begin
          report_mismatch("transfer with nothing expected", got.word, '0);
        end else begin
          want = pending_words.pop_front();
          if (got.word !== want.word) report_mismatch("out_word", got.word, want.word);
          if (got.frame_last !== want.frame_last)
            report_mismatch("frame_last", 24'(got.frame_last), 24'(want.frame_last));
          if (got.stream_end !== want.stream_end)
            report_mismatch("stream_end", 24'(got.stream_end), 24'(want.stream_end));
        end
      end
      if (choke_req) begin
        choke_req  = 1'b0;
        stall_left = CHOKE_CYCLES;
        calm_left  = 0;
      end else if (stall_left == 0 && calm_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 4) calm_left = $urandom_range(20, 80);
        else if (r < 30) stall_left = idle_len();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (calm_left > 0) calm_left--;
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int                    sent;
    int                    phase;
    int                    n;
    bit                    calm;
    logic [3:0]            cc;
    logic [63:0]           target;
    logic [63:0]           scale;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.first_byte  = '0;
    in_if.second_byte = '0;
    cfg_we            = 1'b0;
    cfg_index         = REG_CHANNEL_COUNT;
    cfg_wdata         = '0;
    m_chans    = CHAN_CNT_RESET;
    m_msb      = 1'b0;
    m_per_word = 1'b0;
    m_native   = 1'b0;
    m_samples  = '0;
    frame_cnt  = '0;
    chan_idx   = '0;
    parity     = 1'b0;
    ended      = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed part; a zero sample count would end the stream after one frame
    add_cfg(REG_SAMPLE_COUNT, SCOUNT_MAX);
    add_pair(8'h00, 8'h00, 1, 24'hFA0000, 0);
    add_pair(8'hFF, 8'hFF, 1, 24'hFAFFFF, 1);
    add_pair(8'h01, 8'h80, 1, 24'h058001, 0);
    add_pair(8'h80, 8'h01, 1, 24'h050180, 1);
    add_cfg(REG_MSB_FIRST_SOURCE, 1);
    add_pair(8'h12, 8'h34, 1, 24'hFA1234, 0);
    add_pair(8'hA5, 8'h5A, 1, 24'hFAA55A, 1);
    add_cfg(REG_MARKER_PER_SAMPLE, 1);
    add_pair(8'hC3, 8'h3C, 1, 24'hFAC33C, 0);
    add_pair(8'h0F, 8'hF0, 1, 24'h050FF0, 1);
    add_cfg(REG_NATIVE_MODE, 1);
    add_pair(8'h01, 8'hAB, 1, 24'h000080, 0);
    add_cfg(REG_MSB_FIRST_SOURCE, 0);
    add_pair(8'h01, 8'hCD, 1, 24'h000001, 1);
    add_cfg(REG_CHANNEL_COUNT, 0);
    add_pair(8'hFF, 8'h00, 1, 24'h0000FF, 1);
    add_cfg(REG_CHANNEL_COUNT, 15);
    add_cfg(REG_NATIVE_MODE, 0);
    add_cfg(REG_MSB_FIRST_SOURCE, 1);
    add_cfg(REG_MARKER_PER_SAMPLE, 0);
    add_pair(8'h55, 8'hAA, 0, '0, 0);
    add_pair(8'hAA, 8'h55, 0, '0, 0);
    add_pair(8'h00, 8'hFF, 0, '0, 0);
    add_pair(8'hFF, 8'h00, 0, '0, 0);
    add_pair(8'h7E, 8'h81, 0, '0, 0);
    // count drops below the current index mid-frame
    add_cfg(REG_CHANNEL_COUNT, 3);
    add_pair(8'h3C, 8'hC3, 0, '0, 0);
    add_cfg(REG_CHANNEL_COUNT, 8);
    for (int i = 0; i < 8; i++) add_pair(8'(i * 17), ~8'(i * 17), 0, '0, 0);

    foreach (script[i]) begin
      if (script[i].kind == STEP_CFG) begin
        drain();
        cfg_write(script[i].sel, script[i].value);
      end else begin
        send_pair(script[i].fb, script[i].sb, script[i].typed, script[i].want, 1'b0);
      end
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_PAIRS) begin
      drain();
      if ($urandom_range(0, 1)) begin
        cc = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 15))
                                         : 4'($urandom_range(1, MAX_CHANNELS));
        cfg_write(REG_CHANNEL_COUNT, CFG_DATA_W'(cc));
      end
      if ($urandom_range(0, 1))
        cfg_write(REG_MSB_FIRST_SOURCE, CFG_DATA_W'($urandom_range(0, 1)));
      if ($urandom_range(0, 1))
        cfg_write(REG_MARKER_PER_SAMPLE, CFG_DATA_W'($urandom_range(0, 1)));
      if ($urandom_range(0, 1))
        cfg_write(REG_NATIVE_MODE, CFG_DATA_W'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) == 0) cfg_write(REG_SAMPLE_COUNT, safe_samples());
      calm = ($urandom_range(0, 4) == 0);
      n    = $urandom_range(8, 50);
      if (phase == 2) begin
        // result side holds off while pairs keep coming, so the input backs up
        choke_req = 1'b1;
        calm      = 1'b1;
        n         = 40;
      end
      repeat (n) begin
        send_pair(rand_byte(), rand_byte(), 1'b0, '0, calm);
        sent++;
      end
      phase++;
    end

    // closing phase: pick a count that ends the stream a few frames on
    drain();
    scale = m_native ? 64'd8 : 64'd16;
    if ($urandom_range(0, 2) == 0) target = '0;
    else target = ({23'd0, frame_cnt} + 64'($urandom_range(1, 4))) * scale
                  - 64'($urandom_range(0, 15) % scale);
    cfg_write(REG_SAMPLE_COUNT, target[SCOUNT_W-1:0]);
    while (!ended) send_pair(rand_byte(), rand_byte(), 1'b0, '0, 1'b0);
    // anything after the end transfers in and is dropped
    repeat (6) send_pair(rand_byte(), rand_byte(), 1'b0, '0, 1'b0);
    drain();
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("** dsd_to_dop_packer: PASSED **");
    end else begin
      $display("** dsd_to_dop_packer: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("** dsd_to_dop_packer: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dsdp_pkg.sv
rtl/dsdp_if.sv
rtl/dsdp_cfg_regs.sv
rtl/dsdp_in_stage.sv
rtl/dsdp_pack_core.sv
rtl/dsd_to_dop_packer.sv
tb/tb_top.sv
